// ===== design/cca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants
// Action and status codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package cca_pkg;

   localparam int CLASSES_DEFAULT   = 64;
   localparam int MAX_BANDS_DEFAULT = 4;
   localparam int BAND_SLOTS        = 4;

   localparam logic [2:0] ACT_CLEAR      = 3'd0;
   localparam logic [2:0] ACT_LOAD_MEAN  = 3'd1;
   localparam logic [2:0] ACT_LOAD_COUNT = 3'd2;
   localparam logic [2:0] ACT_PIXEL      = 3'd3;
   localparam logic [2:0] ACT_READ       = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SMALL_CNT = 2'd1;
   localparam logic [1:0] ST_SATURATED = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       mean_wr;
      logic       cnt_wr;
      logic       clr_step;
      logic       mean_rd;
      logic       diff_wr;
      logic [1:0] rd_band;
      logic [1:0] wr_band;
      logic       acc_rd_pix;
      logic       acc_wr;
      logic [1:0] pa;
      logic [1:0] pb;
      logic       rd_fetch;
      logic       rd_eval;
      logic       div_start;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic       in_cls_ok;
      logic       clr_last;
      logic       need_div;
      logic       div_last;
      logic       out_free;
      logic [2:0] nb;
   } stat_type;

   // lower-triangle slot of pair (hi, lo), lo <= hi
   function automatic logic [3:0] pair_slot(input logic [1:0] hi, input logic [1:0] lo);
      logic [3:0] h;
      logic [3:0] tri_n;
      h     = {2'b00, hi};
      tri_n = (h * (h + 4'd1)) >> 1;
      return tri_n + {2'b00, lo};
   endfunction

endpackage

// ===== design/cca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/cca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_ctrl: sequencing state machine
// Steps clear sweeps, mean fetches, pair updates and covariance reads.
// ----------------------------------------------------------------------------
module cca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_action,
   input  cca_pkg::stat_type stat,
   output cca_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_CLR      = 9'b000000010,
      S_MEAN     = 9'b000000100,
      S_PAIR_RD  = 9'b000001000,
      S_PAIR_WR  = 9'b000010000,
      S_RD_FETCH = 9'b000100000,
      S_RD_EVAL  = 9'b001000000,
      S_DIV      = 9'b010000000,
      S_OUT      = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] pa_ff, pa_in;
   logic [1:0] pb_ff, pb_in;
   logic       accept;
   logic [2:0] k_prev;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign k_prev     = k_ff - 3'd1;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      cmd      = '0;
      cmd.rd_band = k_ff[1:0];
      cmd.wr_band = k_prev[1:0];
      cmd.pa      = pa_ff;
      cmd.pb      = pb_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_action)
                  cca_pkg::ACT_CLEAR:      state_in = S_CLR;
                  cca_pkg::ACT_LOAD_MEAN:  cmd.mean_wr = 1'b1;
                  cca_pkg::ACT_LOAD_COUNT: cmd.cnt_wr = 1'b1;
                  cca_pkg::ACT_PIXEL: begin
                     if (stat.in_cls_ok) begin
                        state_in = S_MEAN;
                        k_in     = 3'd0;
                     end
                  end
                  cca_pkg::ACT_READ:       state_in = S_RD_FETCH;
                  default:                 state_in = S_IDLE;
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_MEAN: begin
            // read of band k overlaps diff write of band k-1
            cmd.mean_rd = (k_ff < stat.nb);
            cmd.diff_wr = (k_ff != 3'd0);
            if (k_ff == stat.nb) begin
               state_in = S_PAIR_RD;
               pa_in    = 2'd0;
               pb_in    = 2'd0;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_PAIR_RD: begin
            cmd.acc_rd_pix = 1'b1;
            state_in       = S_PAIR_WR;
         end
         S_PAIR_WR: begin
            cmd.acc_wr = 1'b1;
            if (({1'b0, pa_ff} == stat.nb - 3'd1) && (pb_ff == pa_ff)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_PAIR_RD;
               if (pb_ff == pa_ff) begin
                  pa_in = pa_ff + 2'd1;
                  pb_in = 2'd0;
               end else begin
                  pb_in = pb_ff + 2'd1;
               end
            end
         end
         S_RD_FETCH: begin
            cmd.rd_fetch = 1'b1;
            state_in     = S_RD_EVAL;
         end
         S_RD_EVAL: begin
            if (stat.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.rd_eval = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         k_ff     <= 3'd0;
         pa_ff    <= 2'd0;
         pb_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
      end
   end

endmodule

// ===== design/cca_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_dpath: covariance datapath
// Mean/count/accumulator memories, pair product, saturating add, divider,
// output register.
// ----------------------------------------------------------------------------
module cca_dpath #(
   parameter int CLASSES   = cca_pkg::CLASSES_DEFAULT,
   parameter int MAX_BANDS = cca_pkg::MAX_BANDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        req_class_id,
   input  logic [1:0]        req_band_a,
   input  logic [1:0]        req_band_b,
   input  logic [23:0]       req_load_value,
   input  logic [15:0]       req_sample [cca_pkg::BAND_SLOTS],
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata,
   input  cca_pkg::cmd_type  cmd,
   output cca_pkg::stat_type stat,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [63:0]       rsp_value,
   output logic [1:0]        rsp_status
);

   localparam int PAIRS      = (MAX_BANDS * (MAX_BANDS + 1)) / 2;
   localparam int MEAN_DEPTH = CLASSES * MAX_BANDS;
   localparam int ACC_DEPTH  = CLASSES * PAIRS;
   localparam int CW  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int MAW = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
   localparam int AAW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

   logic [2:0]  bands_ff;
   logic [2:0]  nb;
   logic        cls_in_ok;
   logic [CW-1:0] cls_in;

   logic          cls_ok_ff;
   logic [CW-1:0] cls_ff;
   logic [1:0]    ba_ff, bb_ff;
   logic [15:0]   samp_ff [cca_pkg::BAND_SLOTS];
   logic signed [24:0] diff_ff [cca_pkg::BAND_SLOTS];
   logic signed [49:0] prod_ff;
   logic [AAW-1:0] pix_addr_ff;
   logic [AAW-1:0] clr_cnt_ff;

   logic           mean_we;
   logic [MAW-1:0] mean_waddr, mean_raddr;
   logic [23:0]    mean_rdata;
   logic [23:0]    cnt_rdata;
   logic           acc_we, acc_re;
   logic [AAW-1:0] acc_waddr, acc_raddr, pix_addr;
   logic [64:0]    acc_wdata, acc_rdata;

   logic [1:0]  rd_hi, rd_lo;
   logic signed [64:0] sum;
   logic        ovf;
   logic [63:0] sat_val;
   logic        band_ok;

   logic        neg_ff, mark_ff;
   logic [63:0] q_ff;
   logic [23:0] d_ff;
   logic [23:0] rem_ff;
   logic [5:0]  div_cnt_ff;
   logic [24:0] rem_sh;
   logic        ge;
   logic [24:0] rem_sub;
   logic [63:0] q_new;

   logic [63:0] res_val_ff;
   logic [1:0]  res_st_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   // ---- config and input decode ----
   always_ff @(posedge clock) begin
      if (reset) begin
         bands_ff <= 3'd4;
      end else if (csr_we) begin
         bands_ff <= csr_wdata;
      end
   end

   assign nb = (bands_ff == 3'd0) ? 3'd1 :
               (bands_ff > 3'(MAX_BANDS)) ? 3'(MAX_BANDS) : bands_ff;

   assign cls_in_ok = !req_class_id[6] &&
                      ({3'b000, req_class_id[5:0]} < 9'(CLASSES));
   assign cls_in    = CW'({2'b00, req_class_id[5:0]});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cls_ok_ff <= cls_in_ok;
         cls_ff    <= cls_in;
         ba_ff     <= req_band_a;
         bb_ff     <= req_band_b;
         samp_ff   <= req_sample;
      end
   end

   // ---- mean and count stores ----
   assign mean_we    = cmd.mean_wr && cls_in_ok && ({1'b0, req_band_a} < 3'(MAX_BANDS));
   assign mean_waddr = MAW'(32'(cls_in) * MAX_BANDS + 32'(req_band_a));
   assign mean_raddr = MAW'(32'(cls_ff) * MAX_BANDS + 32'(cmd.rd_band));

   cca_ram #(.WIDTH(24), .DEPTH(MEAN_DEPTH)) u_mean_ram (
      .clock (clock),
      .we    (mean_we),
      .waddr (mean_waddr),
      .wdata (req_load_value),
      .re    (cmd.mean_rd),
      .raddr (mean_raddr),
      .rdata (mean_rdata)
   );

   cca_ram #(.WIDTH(24), .DEPTH(CLASSES)) u_count_ram (
      .clock (clock),
      .we    (cmd.cnt_wr && cls_in_ok),
      .waddr (cls_in),
      .wdata (req_load_value),
      .re    (cmd.rd_fetch),
      .raddr (cls_ff),
      .rdata (cnt_rdata)
   );

   // sample widened to 16.8 minus mean
   always_ff @(posedge clock) begin
      if (cmd.diff_wr) begin
         diff_ff[cmd.wr_band] <= $signed({1'b0, samp_ff[cmd.wr_band], 8'h00}) -
                                 $signed({1'b0, mean_rdata});
      end
   end

   // ---- accumulators: {sticky mark, value} ----
   assign rd_hi    = (ba_ff >= bb_ff) ? ba_ff : bb_ff;
   assign rd_lo    = (ba_ff >= bb_ff) ? bb_ff : ba_ff;
   assign pix_addr = AAW'(32'(cls_ff) * PAIRS + 32'(cca_pkg::pair_slot(cmd.pa, cmd.pb)));
   assign acc_re   = cmd.acc_rd_pix || cmd.rd_fetch;
   assign acc_raddr = cmd.rd_fetch ?
                      AAW'(32'(cls_ff) * PAIRS + 32'(cca_pkg::pair_slot(rd_hi, rd_lo))) :
                      pix_addr;

   always_ff @(posedge clock) begin
      if (cmd.acc_rd_pix) begin
         prod_ff     <= diff_ff[cmd.pa] * diff_ff[cmd.pb];
         pix_addr_ff <= pix_addr;
      end
   end

   assign sum     = $signed({acc_rdata[63], acc_rdata[63:0]}) +
                    $signed({{15{prod_ff[49]}}, prod_ff});
   assign ovf     = sum[64] != sum[63];
   assign sat_val = !ovf ? sum[63:0] :
                    (sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

   assign acc_we    = cmd.clr_step || cmd.acc_wr;
   assign acc_waddr = cmd.clr_step ? clr_cnt_ff : pix_addr_ff;
   assign acc_wdata = cmd.clr_step ? 65'd0 : {acc_rdata[64] | ovf, sat_val};

   cca_ram #(.WIDTH(65), .DEPTH(ACC_DEPTH)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .re    (acc_re),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= stat.clr_last ? '0 : clr_cnt_ff + AAW'(1);
      end
   end

   // ---- read evaluation and restoring divider ----
   assign band_ok = ({1'b0, ba_ff} < nb) && ({1'b0, bb_ff} < nb);

   assign rem_sh  = {rem_ff, q_ff[63]};
   assign ge      = rem_sh >= {1'b0, d_ff};
   assign rem_sub = rem_sh - {1'b0, d_ff};
   assign q_new   = {q_ff[62:0], ge};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         mark_ff    <= acc_rdata[64];
         neg_ff     <= acc_rdata[63];
         q_ff       <= acc_rdata[63] ? (64'd0 - acc_rdata[63:0]) : acc_rdata[63:0];
         d_ff       <= cnt_rdata - 24'd1;
         rem_ff     <= 24'd0;
         div_cnt_ff <= 6'd0;
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? rem_sub[23:0] : rem_sh[23:0];
         q_ff       <= q_new;
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
      if (cmd.rd_eval) begin
         res_val_ff <= 64'd0;
         res_st_ff  <= (cls_ok_ff && !band_ok) ? cca_pkg::ST_OK : cca_pkg::ST_SMALL_CNT;
      end else if (cmd.div_step && stat.div_last) begin
         res_val_ff <= neg_ff ? (64'd0 - q_new) : q_new;
         res_st_ff  <= mark_ff ? cca_pkg::ST_SATURATED : cca_pkg::ST_OK;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff  <= res_val_ff;
         rsp_status_ff <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign stat.in_cls_ok = cls_in_ok;
   assign stat.clr_last  = (clr_cnt_ff == AAW'(ACC_DEPTH - 1));
   assign stat.need_div  = cls_ok_ff && band_ok && (cnt_rdata > 24'd1);
   assign stat.div_last  = (div_cnt_ff == 6'd63);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.nb        = nb;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken word");

   a_small_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cca_pkg::ST_SMALL_CNT) |-> (rsp_value_ff == 64'd0))
      else $error("small-count result carries a value");

   a_diff_band: assert property (@(posedge clock) disable iff (reset)
      cmd.diff_wr |-> ({1'b0, cmd.wr_band} < nb))
      else $error("diff written for an unused band");

   a_div_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (cmd.div_step && div_cnt_ff == 6'd0))
      else $error("divider did not start after load");
`endif

endmodule

// ===== design/class_covariance_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_covariance_accumulator_unit: per-class band covariance accumulator
// Accumulates lower-triangle covariance sums per class and answers reads
// divided by count minus one.
// ----------------------------------------------------------------------------
//  channel | direction | ports                       | word
//  req     | in        | req_tvalid/tready/tdata/tuser | one action
//  rsp     | out       | rsp_tvalid/tready/tdata/tuser | one read result
//  csr     | in        | csr_we/csr_wdata            | bands_in_use
//
//  Loads, unused codes and unlabeled pixels finish when accepted; a pixel
//  makes one mean read per band, then a read and an update per pair.
//  A read that divides runs the one-bit-per-cycle divider over the quotient;
//  other reads skip it. A read waits while an untaken result holds the output.
//  A clear sweeps the accumulator memory one entry a cycle, CLASSES*pairs
//  entries (640 by default); a sweep also runs after reset.
//  The result register lets the next word enter while a result waits.
// ----------------------------------------------------------------------------
module class_covariance_accumulator_unit #(
   parameter int CLASSES   = cca_pkg::CLASSES_DEFAULT,
   parameter int MAX_BANDS = cca_pkg::MAX_BANDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // class_id[6:0], band_a[8:7], band_b[10:9], load_value[34:11],
   // sample_band0[50:35], sample_band1[66:51], sample_band2[82:67],
   // sample_band3[98:83], zero fill
   input  logic [103:0] req_tdata,
   // action[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // covariance_value[63:0]
   output logic [63:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_wdata
);

   cca_pkg::cmd_type  cmd;
   cca_pkg::stat_type stat;
   logic [15:0]       samples [cca_pkg::BAND_SLOTS];

   assign samples[0] = req_tdata[50:35];
   assign samples[1] = req_tdata[66:51];
   assign samples[2] = req_tdata[82:67];
   assign samples[3] = req_tdata[98:83];

   cca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   cca_dpath #(.CLASSES(CLASSES), .MAX_BANDS(MAX_BANDS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_class_id   (req_tdata[6:0]),
      .req_band_a     (req_tdata[8:7]),
      .req_band_b     (req_tdata[10:9]),
      .req_load_value (req_tdata[34:11]),
      .req_sample     (samples),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_value      (rsp_tdata),
      .rsp_status     (rsp_tuser)
   );

endmodule
